// File: rtl/lzsd_pkg.sv
// Shared constants and types for the LZSS byte-stream decoder.
// No dependencies.
package lzsd_pkg;

  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int START_W         = 12;
  localparam logic [START_W-1:0] WIN_START_RST = 12'hFEE;
  localparam logic [7:0]         FLAG_FILL     = 8'hFF;

  // token phase codes
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_HIGH  = 2'd2,
    PH_SPARE = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EMIT = 5'b00010,
    ST_READ = 5'b00100,
    ST_COPY = 5'b01000,
    ST_END  = 5'b10000
  } state_t;

endpackage

// File: rtl/lzss_byte_stream_decoder.sv
// LZSS decoder, 4 KiB history window, one compressed byte per input transfer.
// Flag and reference low bytes are taken while idle; a literal passes through EMIT;
// a reference alternates READ and COPY per byte (one window port: read, then write);
// end of stream adds END for the end marker. Not ready while busy.
// Reset: synchronous, active high. The window reads as zero until written,
// tracked by a fill count against the stream's base pointer; no clearing pass.
module lzss_byte_stream_decoder
  import lzsd_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  localparam int ADDR_W = $clog2(WINDOW_SIZE)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [ADDR_W-1:0] cfg_data,   // window_start
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,    // in_byte
  input  logic              s_tlast,    // stream_last
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,    // out_byte[7:0], total_count[39:8]
  output logic              m_tlast,    // run_last
  output logic [1:0]        m_tuser     // byte_valid[0], stream_done[1]
);

  state_t            state;
  phase_t            phase;
  logic [15:0]       flag_shift;
  logic [7:0]        offset_low;
  logic [31:0]       count;
  logic [ADDR_W-1:0] window_start;
  logic [ADDR_W-1:0] wptr;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W:0]   fill;
  logic              last_q;
  logic [7:0]        lit_byte;
  logic [ADDR_W-1:0] src;
  logic [4:0]        remain;
  logic [7:0]        rd_data;
  logic              rd_ok;

  logic [7:0]        mem [WINDOW_SIZE];

  logic              slot_free;
  logic              emit_fire;
  logic [7:0]        emit_byte;
  logic [15:0]       flag_shifted;
  phase_t            phase_after;
  logic [ADDR_W-1:0] src_ofs;

  assign s_tready     = (state == ST_IDLE);
  assign slot_free    = !m_tvalid || m_tready;
  assign emit_fire    = ((state == ST_EMIT) || (state == ST_COPY)) && slot_free;
  assign emit_byte    = (state == ST_EMIT) ? lit_byte : (rd_ok ? rd_data : 8'd0);
  assign flag_shifted = flag_shift >> 1;
  assign phase_after  = flag_shifted[8] ? PH_TOKEN : PH_FLAG;
  // entries written this stream lie in [base, base + fill)
  assign src_ofs      = src - base;

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      mem[wptr] <= emit_byte;
    end
    if (state == ST_READ) begin
      rd_data <= mem[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_FLAG;
      flag_shift   <= '0;
      offset_low   <= '0;
      count        <= '0;
      window_start <= ADDR_W'(WIN_START_RST);
      wptr         <= ADDR_W'(WIN_START_RST);
      base         <= ADDR_W'(WIN_START_RST);
      fill         <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wen) begin
        window_start <= cfg_data;
        if (flag_shift == 16'd0) begin
          wptr <= cfg_data;
          base <= cfg_data;
        end
      end

      if (emit_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {32'd0, emit_byte};
        m_tuser  <= 2'b01;
        wptr     <= wptr + 1'b1;
        count    <= count + 32'd1;
        if (!fill[ADDR_W]) begin
          fill <= fill + 1'b1;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            last_q <= s_tlast;
            unique case (phase)
              PH_TOKEN: begin
                if (flag_shift[0]) begin
                  lit_byte   <= s_tdata;
                  flag_shift <= flag_shifted;
                  phase      <= phase_after;
                  state      <= ST_EMIT;
                end else begin
                  offset_low <= s_tdata;
                  phase      <= PH_HIGH;
                  state      <= s_tlast ? ST_END : ST_IDLE;
                end
              end
              PH_HIGH: begin
                src    <= ADDR_W'({s_tdata[7:4], offset_low});
                // copy length is nibble + 3; count down to zero
                remain <= 5'(s_tdata[3:0]) + 5'd2;
                state  <= ST_READ;
              end
              default: begin
                flag_shift <= {FLAG_FILL, s_tdata};
                phase      <= PH_TOKEN;
                state      <= s_tlast ? ST_END : ST_IDLE;
              end
            endcase
          end
        end
        ST_READ: begin
          rd_ok <= fill[ADDR_W] || (src_ofs < fill[ADDR_W-1:0]);
          state <= ST_COPY;
        end
        ST_EMIT: begin
          if (slot_free) begin
            m_tlast <= !last_q;
            state   <= last_q ? ST_END : ST_IDLE;
          end
        end
        ST_COPY: begin
          if (slot_free) begin
            src <= src + 1'b1;
            if (remain == 5'd0) begin
              flag_shift <= flag_shifted;
              phase      <= phase_after;
              m_tlast    <= !last_q;
              state      <= last_q ? ST_END : ST_IDLE;
            end else begin
              remain  <= remain - 5'd1;
              m_tlast <= 1'b0;
              state   <= ST_READ;
            end
          end
        end
        ST_END: begin
          if (slot_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {count, 8'd0};
            m_tuser    <= 2'b10;
            m_tlast    <= 1'b1;
            // new stream
            phase      <= PH_FLAG;
            flag_shift <= '0;
            offset_low <= '0;
            count      <= '0;
            wptr       <= window_start;
            base       <= window_start;
            fill       <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: dv/lzss_byte_stream_decoder_tb.sv
// Self-checking testbench for lzss_byte_stream_decoder: directed table, then random streams.
// Keeps its own window/flag/phase decoder state and checks every output transfer.
// Depends on lzsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module lzss_byte_stream_decoder_tb;
  import lzsd_pkg::*;

  typedef struct packed {
    logic [31:0] total;
    logic        done;
    logic        run_last;
    logic        valid;
    logic [7:0]  data;
  } dec_res_t;

  typedef enum {ROW_PRED, ROW_LIT, ROW_DONE} row_kind_t;

  typedef struct {
    logic [7:0]  b;
    logic        l;
    row_kind_t   kind;
    logic [31:0] cnt;
  } dir_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [START_W-1:0] cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [39:0]        m_tdata;    // out_byte[7:0], total_count[39:8]
  logic               m_tlast;    // run_last
  logic [1:0]         m_tuser;    // byte_valid[0], stream_done[1]

  lzss_byte_stream_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // decoder state as seen by the testbench
  logic [7:0]         win_mem [0:4095];
  logic [11:0]        win_wp;
  logic [11:0]        win_base;
  logic [15:0]        flag_sr;
  phase_t             tok_ph;
  logic [7:0]         ref_lo;
  logic [31:0]        out_cnt;

  dec_res_t           step_q[$];
  dec_res_t           decoded_q[$];
  dir_row_t           dir_tab [0:20];
  int                 errs = 0;
  int                 n_sent = 0;
  bit                 idle_on = 1'b1;
  int                 stall_left = 0;
  dec_res_t           got_res;
  dec_res_t           want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("lzss_byte_stream_decoder_tb failed");
    $finish;
  end

  function automatic void new_stream();
    for (int i = 0; i < 4096; i++) win_mem[i] = 8'h00;
    win_wp  = win_base;
    flag_sr = '0;
    tok_ph  = PH_FLAG;
    ref_lo  = '0;
    out_cnt = '0;
  endfunction

  function automatic void put_byte(input logic [7:0] d);
    win_mem[win_wp] = d;
    win_wp  = win_wp + 12'd1;
    out_cnt = out_cnt + 32'd1;
    step_q.insert(step_q.size(), dec_res_t'{32'd0, 1'b0, 1'b0, 1'b1, d});
  endfunction

  function automatic void next_tok();
    flag_sr = flag_sr >> 1;
    tok_ph  = flag_sr[8] ? PH_TOKEN : PH_FLAG;
  endfunction

  // results caused by one accepted input byte go to step_q
  function automatic void decode_byte(input logic [7:0] b, input logic l);
    logic [11:0] off;
    int          len;
    step_q.delete();
    case (tok_ph)
      PH_TOKEN: begin
        if (flag_sr[0]) begin
          put_byte(b);
          next_tok();
        end else begin
          ref_lo = b;
          tok_ph = PH_HIGH;
        end
      end
      PH_HIGH: begin
        off = {b[7:4], ref_lo};
        len = int'(b[3:0]) + 3;
        // byte by byte, so an overlapping copy sees what it just wrote
        for (int i = 0; i < len; i++) put_byte(win_mem[off + 12'(i)]);
        next_tok();
      end
      default: begin
        flag_sr = {FLAG_FILL, b};
        tok_ph  = PH_TOKEN;
      end
    endcase
    if (l) begin
      step_q.insert(step_q.size(), dec_res_t'{out_cnt, 1'b1, 1'b0, 1'b0, 8'h00});
      new_stream();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l, input bit use_pred);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, l);
    if (use_pred) foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
    n_sent++;
    idle_on = (n_sent < 320);
  endtask

  task automatic write_window_start(input logic [11:0] v);
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // a flag byte leaves no result behind, give it time to settle
    repeat (8) @(posedge clk);
    cfg_wen  <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_wen  <= 1'b0;
    win_base = v;
    if (flag_sr == 16'h0000) win_wp = v;
  endtask

  // ntok tokens; a broken stream ends on one extra byte in whatever phase it lands
  task automatic send_stream(input int ntok, input bit broken);
    int          k;
    logic [7:0]  flag;
    logic [11:0] off;
    logic [3:0]  ln;
    logic        fin;
    k = 0;
    while (k < ntok) begin
      case ($urandom_range(0, 5))
        0:       flag = 8'h00;
        1:       flag = 8'hFF;
        default: flag = 8'($urandom_range(0, 255));
      endcase
      send_item(flag, 1'b0, 1'b1);
      for (int t = 0; t < 8 && k < ntok; t++) begin
        fin = !broken && (k == ntok - 1);
        if (flag[t]) begin
          send_item(8'($urandom_range(0, 255)), fin, 1'b1);
        end else begin
          // mostly point back into recently written bytes
          if ($urandom_range(0, 3) != 0) off = win_wp - 12'($urandom_range(1, 64));
          else off = 12'($urandom_range(0, 4095));
          ln = 4'($urandom_range(0, 15));
          send_item(off[7:0], 1'b0, 1'b1);
          send_item({off[11:8], ln}, fin, 1'b1);
        end
        k++;
      end
    end
    if (broken) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // receive side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res = {m_tdata[39:8], m_tuser[1], m_tlast, m_tuser[0], m_tdata[7:0]};
      if (decoded_q.size() == 0) begin
        errs++;
        $display("%0t: unexpected transfer data=%02h valid=%0b last=%0b done=%0b count=%0d",
                 $time, got_res.data, got_res.valid, got_res.run_last, got_res.done,
                 got_res.total);
      end else begin
        want_res = decoded_q.pop_front();
        if (got_res !== want_res) begin
          errs++;
          $display({"%0t: mismatch exp data=%02h valid=%0b last=%0b done=%0b count=%0d",
                    " got data=%02h valid=%0b last=%0b done=%0b count=%0d"},
                   $time, want_res.data, want_res.valid, want_res.run_last,
                   want_res.done, want_res.total, got_res.data, got_res.valid,
                   got_res.run_last, got_res.done, got_res.total);
        end
      end
    end
  end

  initial begin
    logic [11:0] v;
    int          base_n;

    dir_tab = '{
      '{8'h03, 1'b0, ROW_PRED, 32'd0},   // flag: lit, lit, then refs
      '{8'h00, 1'b0, ROW_LIT,  32'd0},
      '{8'hFF, 1'b0, ROW_LIT,  32'd0},
      '{8'hEE, 1'b0, ROW_PRED, 32'd0},
      '{8'hF0, 1'b0, ROW_PRED, 32'd0},   // len 3 copy overlapping its own output
      '{8'h00, 1'b0, ROW_PRED, 32'd0},
      '{8'h0F, 1'b0, ROW_PRED, 32'd0},   // offset 0, len 18, untouched window
      '{8'hFF, 1'b0, ROW_PRED, 32'd0},
      '{8'hFF, 1'b0, ROW_PRED, 32'd0},   // offset 0xfff, wraps the window
      '{8'h12, 1'b1, ROW_DONE, 32'd41},  // half a reference dropped at end of stream
      '{8'hFF, 1'b1, ROW_DONE, 32'd0},   // flag byte ends an empty stream
      '{8'h01, 1'b0, ROW_PRED, 32'd0},
      '{8'h5A, 1'b1, ROW_PRED, 32'd0},   // literal plus end marker
      '{8'hFE, 1'b0, ROW_PRED, 32'd0},
      '{8'h34, 1'b0, ROW_PRED, 32'd0},
      '{8'h1F, 1'b0, ROW_PRED, 32'd0},
      '{8'hA5, 1'b0, ROW_LIT,  32'd0},
      '{8'h3C, 1'b1, ROW_PRED, 32'd0},
      '{8'h00, 1'b0, ROW_PRED, 32'd0},
      '{8'h10, 1'b0, ROW_PRED, 32'd0},
      '{8'h25, 1'b1, ROW_PRED, 32'd0}    // reference high byte ends the stream
    };

    win_base = WIN_START_RST;
    new_stream();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].b, dir_tab[i].l, dir_tab[i].kind == ROW_PRED);
      if (dir_tab[i].kind == ROW_LIT)
        decoded_q.insert(decoded_q.size(),
                         dec_res_t'{32'd0, 1'b0, 1'b1, 1'b1, dir_tab[i].b});
      else if (dir_tab[i].kind == ROW_DONE)
        decoded_q.insert(decoded_q.size(),
                         dec_res_t'{dir_tab[i].cnt, 1'b1, 1'b1, 1'b0, 8'h00});
    end

    for (int ph = 0; n_sent < 370; ph++) begin
      // a flag byte already taken defers the new start position to the next stream
      if (ph == 3) send_item(8'h55, 1'b0, 1'b1);
      case (ph)
        0:       v = 12'h000;
        1:       v = 12'hFFF;
        default: v = 12'($urandom_range(0, 4095));
      endcase
      if (ph < 4 || $urandom_range(0, 2) != 0) write_window_start(v);
      base_n = n_sent;
      while (n_sent - base_n < 40 && n_sent < 370) begin
        case ($urandom_range(0, 9))
          0:       send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
          1:       send_stream($urandom_range(1, 12), 1'b1);
          default: send_stream($urandom_range(1, 20), 1'b0);
        endcase
      end
    end

    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errs == 0) begin
      $display("lzss_byte_stream_decoder_tb passed");
    end else begin
      $display("lzss_byte_stream_decoder_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lzsd_pkg.sv
rtl/lzss_byte_stream_decoder.sv
dv/lzss_byte_stream_decoder_tb.sv
